/* sv/mtcl_pkg.sv */
// Shared types and codes for the multi-threshold crossing latch.
`default_nettype none

package mtcl_pkg;

    // Item action codes; codes above ACT_RESET do nothing
    typedef enum logic [2:0] {
        ACT_COMPARE = 3'd0,
        ACT_SET     = 3'd1,
        ACT_DEFINE  = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_RESET   = 3'd4
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CMP,
        S_SWEEP,
        S_COPY,
        S_WIPE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/mtcl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, then registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/mtcl_cmp.sv */
// Shared signed greater-or-equal compare unit used by the compare, scan, wipe and copy steps.
`default_nettype none

module mtcl_cmp #(
    parameter int WIDTH = 33
) (
    input  wire logic signed [WIDTH-1:0] opa,
    input  wire logic signed [WIDTH-1:0] opb,
    output logic                         ge
);

    // Compare as two's complement integers
    assign ge = (opa >= opb);

endmodule

`default_nettype wire

/* sv/multi_threshold_crossing_latch.sv */
// Top level: sequencer, flag store and result register of the crossing latch.
//
// Usage: items arrive on in_valid/in_ready carrying action, sample_value and
// last_element; every item yields exactly one result on out_valid/out_ready
// carrying crossed and latch_status. in_ready is high only while the
// sequencer is idle, so one item is in work at a time.
// Steps per item, from acceptance to the result being loaded:
//   a compare element reads its threshold and updates its met flag; set and
//   define elements write their entry and unused codes do nothing; clear
//   wipes the met flags of the active list; a define element that ends a list
//   wipes the flags of the new list, a set element that ends a list the flags
//   of the added entries; a compare or set element that ends a list then scans
//   the met flags, one flag a cycle, and stops just after the first clear flag;
//   reset copies the creation table into the working table, which also clears
//   the flags.
// The flag scan, the flag wipe and the table copy share one compare unit and
// set the rate. After rst_n the block runs a clearing pass over the threshold
// and flag RAMs with in_ready low. A result waits in the output register while
// the receiver stalls; the next item is still accepted and worked on, and its
// result is held back until the register is free.
`default_nettype none

module multi_threshold_crossing_latch #(
    parameter int MAX_ENTRIES = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    action,
    input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
    input  wire logic                          last_element,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               crossed,
    output logic                               latch_status
);

    import mtcl_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int UW = (VALUE_WIDTH > CW + 1) ? VALUE_WIDTH : CW + 1;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic [CW-1:0]            active_reg, active_next;
    logic [CW-1:0]            ccount_reg, ccount_next;
    logic                     latch_reg, latch_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;

    logic [IW-1:0]            wr_idx_reg, wr_idx_next;
    logic [2:0]               action_reg, action_next;
    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                     last_reg, last_next;
    logic                     sweep_cmp_reg, sweep_cmp_next;
    logic                     res_crossed_reg, res_crossed_next;
    logic                     crossed_reg, crossed_next;
    logic                     status_reg, status_next;

    logic                     work_we, work_re;
    logic [IW-1:0]            work_wr_addr, work_rd_addr;
    logic [VALUE_WIDTH-1:0]   work_wr_data, work_rd_data;
    logic                     cre_we, cre_re;
    logic [IW-1:0]            cre_wr_addr, cre_rd_addr;
    logic [VALUE_WIDTH-1:0]   cre_wr_data, cre_rd_data;
    logic                     flag_we, flag_re;
    logic [IW-1:0]            flag_wr_addr, flag_rd_addr;
    logic [0:0]               flag_wr_data, flag_rd_data;

    logic signed [UW-1:0]     opa, opb;
    logic                     ge;

    logic                     in_range;
    logic [CW-1:0]            new_count;
    logic [CW-1:0]            pos_adv;
    logic [IW-1:0]            pos_idx;

    // Threshold tables
    mtcl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_work_ram (
        .clk     (clk),
        .wr_en   (work_we),
        .wr_addr (work_wr_addr),
        .wr_data (work_wr_data),
        .rd_en   (work_re),
        .rd_addr (work_rd_addr),
        .rd_data (work_rd_data)
    );

    mtcl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_cre_ram (
        .clk     (clk),
        .wr_en   (cre_we),
        .wr_addr (cre_wr_addr),
        .wr_data (cre_wr_data),
        .rd_en   (cre_re),
        .rd_addr (cre_rd_addr),
        .rd_data (cre_rd_data)
    );

    // Met flags; entries at or above the active count are never read before
    // they are wiped
    mtcl_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_flag_ram (
        .clk     (clk),
        .wr_en   (flag_we),
        .wr_addr (flag_wr_addr),
        .wr_data (flag_wr_data),
        .rd_en   (flag_re),
        .rd_addr (flag_rd_addr),
        .rd_data (flag_rd_data)
    );

    // Shared compare unit
    mtcl_cmp #(.WIDTH(UW)) u_cmp (
        .opa (opa),
        .opb (opb),
        .ge  (ge)
    );

    // List position helpers
    assign in_range  = (pos_reg < CW'(MAX_ENTRIES));
    assign new_count = in_range ? (pos_reg + CW'(1)) : CW'(MAX_ENTRIES);
    assign pos_idx   = pos_reg[IW-1:0];
    assign pos_adv   = last_reg ? '0 : (in_range ? (pos_reg + CW'(1)) : pos_reg);

    // Steer the compare unit by sequencer step
    always_comb
    begin
        case (state_reg)
            S_CMP:
            begin
                opa = UW'(value_reg);
                opb = UW'($signed(work_rd_data));
            end
            S_COPY:
            begin
                opa = UW'(idx_reg);
                opb = UW'(ccount_reg);
            end
            default:
            begin
                opa = UW'(idx_reg);
                opb = UW'(active_reg);
            end
        endcase
    end

    // Sequencer: next state, table access and result
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        active_next      = active_reg;
        ccount_next      = ccount_reg;
        latch_next       = latch_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        wr_idx_next      = wr_idx_reg;
        action_next      = action_reg;
        value_next       = value_reg;
        last_next        = last_reg;
        sweep_cmp_next   = sweep_cmp_reg;
        res_crossed_next = res_crossed_reg;
        crossed_next     = crossed_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        in_ready         = 1'b0;

        work_we      = 1'b0;
        work_wr_addr = pos_idx;
        work_wr_data = value_reg;
        work_re      = 1'b0;
        work_rd_addr = pos_idx;
        cre_we       = 1'b0;
        cre_wr_addr  = pos_idx;
        cre_wr_data  = value_reg;
        cre_re       = 1'b0;
        cre_rd_addr  = idx_reg[IW-1:0];
        flag_we      = 1'b0;
        flag_wr_addr = idx_reg[IW-1:0];
        flag_wr_data = '0;
        flag_re      = 1'b0;
        flag_rd_addr = idx_reg[IW-1:0];

        case (state_reg)
            S_INIT:
            begin
                // Zero the tables and the flags, one entry a cycle
                work_we      = 1'b1;
                work_wr_addr = idx_reg[IW-1:0];
                work_wr_data = '0;
                cre_we       = 1'b1;
                cre_wr_addr  = idx_reg[IW-1:0];
                cre_wr_data  = '0;
                flag_we      = 1'b1;
                if (idx_reg == CW'(MAX_ENTRIES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    action_next = action;
                    value_next  = sample_value;
                    last_next   = last_element;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_crossed_next = 1'b0;
                state_next       = S_DONE;
                case (action_reg)
                    ACT_COMPARE:
                    begin
                        pos_next    = pos_adv;
                        wr_idx_next = pos_idx;
                        if (in_range && (pos_reg < active_reg))
                        begin
                            work_re    = 1'b1;
                            state_next = S_CMP;
                        end
                        else if (last_reg)
                        begin
                            idx_next       = '0;
                            pend_next      = 1'b0;
                            sweep_cmp_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                    end
                    ACT_SET:
                    begin
                        pos_next = pos_adv;
                        work_we  = in_range;
                        if (last_reg)
                        begin
                            // Wipe flags that the grown list adds, then rescan
                            active_next    = new_count;
                            idx_next       = active_reg;
                            sweep_cmp_next = 1'b0;
                            state_next     = S_WIPE;
                        end
                    end
                    ACT_DEFINE:
                    begin
                        pos_next = pos_adv;
                        work_we  = in_range;
                        cre_we   = in_range;
                        if (last_reg)
                        begin
                            active_next = new_count;
                            ccount_next = new_count;
                            latch_next  = 1'b0;
                            idx_next    = '0;
                            state_next  = S_WIPE;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        latch_next = 1'b0;
                        pos_next   = '0;
                        idx_next   = '0;
                        state_next = S_WIPE;
                    end
                    ACT_RESET:
                    begin
                        active_next = ccount_reg;
                        latch_next  = 1'b0;
                        pos_next    = '0;
                        idx_next    = '0;
                        pend_next   = 1'b0;
                        state_next  = S_COPY;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CMP:
            begin
                // Update the element's met flag from the threshold read
                flag_we      = 1'b1;
                flag_wr_addr = wr_idx_reg;
                flag_wr_data = ge;
                if (last_reg)
                begin
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    sweep_cmp_next = 1'b1;
                    state_next     = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_WIPE:
            begin
                // Clear flags up to the active count, one a cycle
                if (!ge)
                begin
                    flag_we  = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                else if (action_reg == ACT_SET)
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SWEEP:
            begin
                // Scan active flags until the end or the first clear one
                if (pend_reg && !flag_rd_data[0])
                begin
                    res_crossed_next = 1'b0;
                    latch_next       = 1'b0;
                    state_next       = S_DONE;
                end
                else if (ge)
                begin
                    res_crossed_next = sweep_cmp_reg & ~latch_reg;
                    latch_next       = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    flag_re   = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
            end

            S_COPY:
            begin
                // Read creation entries and write each one in the next cycle
                if (pend_reg)
                begin
                    work_we      = 1'b1;
                    work_wr_addr = wr_idx_reg;
                    work_wr_data = cre_rd_data;
                end
                if (!ge)
                begin
                    cre_re      = 1'b1;
                    flag_we     = 1'b1;
                    wr_idx_next = idx_reg[IW-1:0];
                    pend_next   = 1'b1;
                    idx_next    = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    crossed_next   = res_crossed_reg;
                    status_next    = latch_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pos_reg       <= '0;
            active_reg    <= CW'(1);
            ccount_reg    <= CW'(1);
            latch_reg     <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            active_reg    <= active_next;
            ccount_reg    <= ccount_next;
            latch_reg     <= latch_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_idx_reg      <= wr_idx_next;
        action_reg      <= action_next;
        value_reg       <= value_next;
        last_reg        <= last_next;
        sweep_cmp_reg   <= sweep_cmp_next;
        res_crossed_reg <= res_crossed_next;
        crossed_reg     <= crossed_next;
        status_reg      <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign crossed      = crossed_reg;
    assign latch_status = status_reg;

    // A reported crossing always leaves the latch set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && crossed) |-> latch_status)
        else $error("crossing reported with latch clear");

    // An accepted item keeps the input closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened straight after acceptance");

    // The active count holds still while the flag scan runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && $past(state_reg) == S_SWEEP) |-> $stable(active_reg))
        else $error("active count moved during flag scan");

    // The active count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != '0) && (active_reg <= CW'(MAX_ENTRIES)))
        else $error("active count out of range");

endmodule

`default_nettype wire

/* tb/mtcl_checker.sv */
// Checker for the crossing latch: predicts every result item and compares it with the block.
`timescale 1ns / 100ps

module mtcl_checker #(
    parameter int MAX_ENTRIES = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [2:0]                    action,
    input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
    input  wire logic                          last_element,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          crossed,
    input  wire logic                          latch_status,
    output int                                 fail_count,
    output int                                 results_due
);

    import mtcl_pkg::*;

    typedef struct packed {
        logic crossed;
        logic latch;
    } latch_result_t;

    // Predicted results, oldest first
    latch_result_t result_queue[$];
    latch_result_t due;

    // Shadow of the block's tables, flags and counters
    logic signed [VALUE_WIDTH-1:0] work_thr [MAX_ENTRIES];
    logic signed [VALUE_WIDTH-1:0] make_thr [MAX_ENTRIES];
    logic                          met      [MAX_ENTRIES];
    int                            live_count;
    int                            made_count;
    int                            next_pos;
    logic                          held;

    // AND of the met flags over the active thresholds
    function automatic bit all_met();
        for (int i = 0; i < live_count; i++)
            if (!met[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Drop every flag and the latch
    function automatic void drop_flags();
        for (int i = 0; i < MAX_ENTRIES; i++)
            met[i] = 1'b0;
        held = 1'b0;
    endfunction

    // Apply one item to the shadow state and return the result it causes
    function automatic latch_result_t advance_latch(input logic [2:0] act,
                                                    input logic signed [VALUE_WIDTH-1:0] val,
                                                    input logic last);
        latch_result_t res;
        int            pos;
        int            grown;
        bit            fits;
        bit            every;
        pos         = next_pos;
        fits        = pos < MAX_ENTRIES;
        grown       = fits ? pos + 1 : MAX_ENTRIES;
        res.crossed = 1'b0;
        if (act == ACT_COMPARE)
        begin
            if (fits && pos < live_count)
                met[pos] = (val >= work_thr[pos]);
            // report only the rising edge of the AND
            if (last)
            begin
                every       = all_met();
                res.crossed = every && !held;
                held        = every;
            end
        end
        else if (act == ACT_SET)
        begin
            if (fits)
                work_thr[pos] = val;
            // keep surviving flags, clear the added ones, re-derive the latch
            if (last)
            begin
                for (int i = live_count; i < grown; i++)
                    met[i] = 1'b0;
                live_count = grown;
                held       = all_met();
            end
        end
        else if (act == ACT_DEFINE)
        begin
            if (fits)
            begin
                make_thr[pos] = val;
                work_thr[pos] = val;
            end
            if (last)
            begin
                live_count = grown;
                made_count = grown;
                drop_flags();
            end
        end
        else if (act == ACT_CLEAR)
        begin
            drop_flags();
        end
        else if (act == ACT_RESET)
        begin
            live_count = made_count;
            for (int i = 0; i < made_count; i++)
                work_thr[i] = make_thr[i];
            drop_flags();
        end
        // one position counter shared by compare, set and define elements
        if (act <= ACT_DEFINE)
            next_pos = last ? 0 : (fits ? pos + 1 : pos);
        else if (act == ACT_CLEAR || act == ACT_RESET)
            next_pos = 0;
        res.latch = held;
        return res;
    endfunction

    // Compare accepted results, then predict for the accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                work_thr[i] = '0;
                make_thr[i] = '0;
                met[i]      = 1'b0;
            end
            live_count  = 1;
            made_count  = 1;
            next_pos    = 0;
            held        = 1'b0;
            fail_count  = 0;
            result_queue.delete();
            results_due = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result item: crossed %0b latch_status %0b",
                             $time, crossed, latch_status);
                    fail_count++;
                end
                else
                begin
                    due = result_queue.pop_front();
                    if (crossed !== due.crossed)
                    begin
                        $display("%0t: crossed expected %0b actual %0b",
                                 $time, due.crossed, crossed);
                        fail_count++;
                    end
                    if (latch_status !== due.latch)
                    begin
                        $display("%0t: latch_status expected %0b actual %0b",
                                 $time, due.latch, latch_status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                result_queue.push_back(advance_latch(action, sample_value, last_element));
            results_due = result_queue.size();
        end
    end

endmodule

/* tb/multi_threshold_crossing_latch_tb.sv */
// Testbench top for the crossing latch: clock, reset, item stimulus and the verdict.
`timescale 1ns / 100ps

module multi_threshold_crossing_latch_tb;

    import mtcl_pkg::*;

    localparam int MAX_ENTRIES     = 256;
    localparam int VALUE_WIDTH     = 32;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int LIMIT_CYCLES    = 1000000;
    localparam int SETTLE_CYCLES   = 600;

    // Codes with no action
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // Q16.16 levels
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [2:0]                    action;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          last_element;
    logic                          out_valid;
    logic                          out_ready;
    logic                          crossed;
    logic                          latch_status;

    int fail_count;
    int results_due;
    int cycle_count;
    int idle_pct;
    int stall_pct;
    int items_sent;

    // Stimulus bookkeeping: list position, counts and which entries hold a value
    int list_pos;
    int live_count;
    int made_count;
    bit wrote_work [MAX_ENTRIES];
    bit wrote_made [MAX_ENTRIES];

    multi_threshold_crossing_latch #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_value (sample_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crossed      (crossed),
        .latch_status (latch_status)
    );

    mtcl_checker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) latch_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_value (sample_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crossed      (crossed),
        .latch_status (latch_status),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Whole part in lo..hi with a random fraction
    function automatic logic signed [31:0] q_level(input int lo, input int hi);
        int whole;
        whole = lo + int'($urandom_range(0, hi - lo));
        return (whole * 65536) + int'($urandom_range(0, 65535));
    endfunction

    // Compare values sit mostly above thresholds so that crossings happen
    function automatic logic signed [31:0] pick_value(input bit for_compare);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return Q_MIN;
        if (roll == 1)
            return Q_MAX;
        if (roll <= 4)
            return $urandom;
        if (for_compare)
            return q_level(-1, 4);
        return q_level(-3, 1);
    endfunction

    // Advance the bookkeeping for one item; a set or define list that would bring
    // a never written entry into use ends as a compare instead
    function automatic logic [2:0] track_item(input logic [2:0] act, input logic last);
        int pos;
        int grown;
        bit fits;
        bit ok;
        pos   = list_pos;
        fits  = pos < MAX_ENTRIES;
        grown = fits ? pos + 1 : MAX_ENTRIES;
        if (last && (act == ACT_SET || act == ACT_DEFINE))
        begin
            ok = 1'b1;
            for (int i = 0; i < grown; i++)
                if (i != pos && (!wrote_work[i] || (act == ACT_DEFINE && !wrote_made[i])))
                    ok = 1'b0;
            if (!ok)
                act = ACT_COMPARE;
        end
        if (act == ACT_SET || act == ACT_DEFINE)
        begin
            if (fits)
            begin
                wrote_work[pos] = 1'b1;
                if (act == ACT_DEFINE)
                    wrote_made[pos] = 1'b1;
            end
            if (last)
            begin
                live_count = grown;
                if (act == ACT_DEFINE)
                    made_count = grown;
            end
        end
        if (act <= ACT_DEFINE)
            list_pos = last ? 0 : (fits ? pos + 1 : pos);
        else if (act == ACT_CLEAR)
            list_pos = 0;
        else if (act == ACT_RESET)
        begin
            live_count = made_count;
            list_pos   = 0;
        end
        return act;
    endfunction

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_item(input logic [2:0] act, input logic signed [31:0] val,
                             input logic last);
        logic [2:0] code;
        code = track_item(act, last);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        action       <= code;
        sample_value <= val;
        last_element <= last;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (code <= ACT_RESET)
            items_sent++;
    endtask

    task automatic send_list(input logic [2:0] act, input int len);
        for (int k = 0; k < len; k++)
            send_item(act, pick_value(act == ACT_COMPARE), k == len - 1);
    endtask

    // Hold off until every predicted result has arrived
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_due == 0);
    endtask

    // One random episode: mostly well-formed lists, some noise and broken lists
    task automatic random_episode();
        int         roll;
        int         len;
        int         pick;
        logic [2:0] code;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            len  = live_count;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = $urandom_range(1, live_count);
            else if (pick < 25)
                len = live_count + $urandom_range(1, 3);
            send_list(ACT_COMPARE, len);
        end
        else if (roll < 67)
            send_list(ACT_SET, $urandom_range(1, 6));
        else if (roll < 73)
            send_list(ACT_DEFINE, $urandom_range(1, 6));
        else if (roll < 79)
            send_item(ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        else if (roll < 84)
            send_item(ACT_RESET, $urandom, 1'($urandom_range(0, 1)));
        else if (roll < 88)
            send_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (roll < 96)
        begin
            // mixed list: each element under its own action
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                code = 3'($urandom_range(ACT_COMPARE, ACT_DEFINE));
                send_item(code, pick_value(code == ACT_COMPARE), k == len - 1);
            end
        end
        else
        begin
            // partial list abandoned by a clear or a reset
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
            begin
                code = 3'($urandom_range(ACT_COMPARE, ACT_DEFINE));
                send_item(code, pick_value(code == ACT_COMPARE), 1'b0);
            end
            send_item($urandom_range(0, 1) ? ACT_CLEAR : ACT_RESET, $urandom,
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int target;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_COMPARE;
        sample_value = '0;
        last_element = 1'b0;
        out_ready    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        cycle_count  = 0;
        items_sent   = 0;
        list_pos     = 0;
        live_count   = 1;
        made_count   = 1;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            wrote_work[i] = 1'b0;
            wrote_made[i] = 1'b0;
        end
        wrote_work[0] = 1'b1;
        wrote_made[0] = 1'b1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Threshold zero: an equal value meets it, one just below drops it
        send_item(ACT_COMPARE, '0, 1'b1);
        send_item(ACT_COMPARE, Q_ONE, 1'b1);
        send_item(ACT_COMPARE, -32'sd1, 1'b1);
        send_item(ACT_COMPARE, Q_MAX, 1'b1);
        send_item(ACT_CLEAR, '0, 1'b1);

        // Define three thresholds: both extremes and one
        send_item(ACT_DEFINE, Q_MIN, 1'b0);
        send_item(ACT_DEFINE, Q_MAX, 1'b0);
        send_item(ACT_DEFINE, Q_ONE, 1'b1);

        // All met; the largest threshold only by the largest value
        send_item(ACT_COMPARE, Q_MIN, 1'b0);
        send_item(ACT_COMPARE, Q_MAX, 1'b0);
        send_item(ACT_COMPARE, Q_ONE, 1'b1);

        // Short list keeps the flags it does not reach
        send_item(ACT_COMPARE, Q_MIN, 1'b1);

        // Too long list with a drop; the element past the table is ignored
        send_item(ACT_COMPARE, Q_ONE, 1'b0);
        send_item(ACT_COMPARE, Q_MAX - 32'sd1, 1'b0);
        send_item(ACT_COMPARE, Q_ONE, 1'b0);
        send_item(ACT_COMPARE, Q_MIN, 1'b1);

        // Set list grows the table by one entry
        send_item(ACT_SET, Q_MIN, 1'b0);
        send_item(ACT_SET, Q_MAX, 1'b0);
        send_item(ACT_SET, '0, 1'b0);
        send_item(ACT_SET, Q_MIN, 1'b1);

        // Partial set list abandoned by a clear, then back to the creation table
        send_item(ACT_SET, Q_ONE, 1'b0);
        send_item(ACT_CLEAR, '0, 1'b0);
        send_item(ACT_RESET, '0, 1'b1);

        // Mixed list ended by a define element
        send_item(ACT_COMPARE, Q_MAX, 1'b0);
        send_item(ACT_SET, -Q_ONE, 1'b0);
        send_item(ACT_DEFINE, '0, 1'b1);

        // Codes with no action
        send_item(ACT_SPARE_LO, Q_MAX, 1'b1);
        send_item(ACT_SPARE_HI, Q_MIN, 1'b0);

        // Random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            if (phase == 0)
            begin
                // Full table: a set list past the end saturates the position,
                // then a full compare list crosses
                send_list(ACT_SET, MAX_ENTRIES + 2);
                for (int k = 0; k < MAX_ENTRIES; k++)
                    send_item(ACT_COMPARE, Q_MAX, k == MAX_ENTRIES - 1);
                send_item(ACT_RESET, $urandom, 1'b0);
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                random_episode();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
